/* design/ssclip_pkg.sv */
// ----------------------------------------------------------------------------
// ssclip_pkg: shared types and constants of the span sprite clip blitter
// register map, configuration record and the records passed between stages
// ----------------------------------------------------------------------------
package ssclip_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned ClipW   = 13;
  localparam int unsigned SrcW    = 20;
  localparam int unsigned DstW    = 24;
  localparam int unsigned RunW    = 11;
  localparam int unsigned CoordW  = 20;
  localparam int unsigned ScrW    = 13;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpriteX     = 3'd0,
    CfgSpriteY     = 3'd1,
    CfgClipLeft    = 3'd2,
    CfgClipTop     = 3'd3,
    CfgClipRight   = 3'd4,
    CfgClipBottom  = 3'd5,
    CfgScreenWidth = 3'd6
  } cfg_idx_e;

  localparam logic [ClipW-1:0] ClipRightRst   = 13'd4096;
  localparam logic [ClipW-1:0] ClipBottomRst  = 13'd4096;
  localparam logic [ClipW-1:0] ScreenWidthRst = 13'd320;

  typedef struct packed {
    logic signed [WordW-1:0] sprite_x;
    logic signed [WordW-1:0] sprite_y;
    logic [ClipW-1:0]        clip_left;
    logic [ClipW-1:0]        clip_top;
    logic [ClipW-1:0]        clip_right;
    logic [ClipW-1:0]        clip_bottom;
    logic [ClipW-1:0]        screen_width;
  } cfg_t;

  // one span item on its way to the clip stage
  typedef struct packed {
    logic             valid;
    logic             draw;
    logic [WordW-1:0] len;
    logic [SrcW-1:0]  src;
  } span_ctx_t;

  // a visible run on its way to the address stage
  typedef struct packed {
    logic            valid;
    logic [ScrW-1:0] scr_row;
    logic [ScrW-1:0] start;
    logic [SrcW-1:0] src;
    logic [RunW-1:0] run;
  } clip_res_t;

endpackage

/* design/span_sprite_clip_blit.sv */
// ----------------------------------------------------------------------------
// span_sprite_clip_blit: clipped run generator for run-length coded sprites
// turns a stream of row headers and span lengths into clipped write runs
// ----------------------------------------------------------------------------
// One span word is taken every clock cycle while the result side keeps up.
// Each word passes three register stages in order (span tracking, clipping,
// address multiply) before its run is offered; headers, transparent spans and
// fully clipped spans leave no item. The whole pipeline holds when a finished
// run is not taken. The user must write configuration only while the block is
// idle; the block itself does not enforce it.
module span_sprite_clip_blit #(
  parameter int unsigned MAX_SPRITE_DIM = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ssclip_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ssclip_pkg::WordW-1:0]      cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // span_word
  input  logic                              s_axis_tuser,  // first_word
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [55:0]                       m_axis_tdata   // dst_index, src_index, run_length
);

  localparam int unsigned DimW = $clog2(MAX_SPRITE_DIM + 1);

  ssclip_pkg::cfg_t             cfg;
  ssclip_pkg::span_ctx_t        ctx;
  ssclip_pkg::clip_res_t        res;
  logic [DimW-1:0]              ctx_col, ctx_row;
  logic                         adv, accept, out_valid;
  logic [ssclip_pkg::DstW-1:0]  dst_index;
  logic [ssclip_pkg::SrcW-1:0]  src_index;
  logic [ssclip_pkg::RunW-1:0]  run_length;

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  ssclip_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ssclip_span_track #(
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM),
    .DimW           (DimW)
  ) u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .adv_i    (adv),
    .word_i   (s_axis_tdata),
    .first_i  (s_axis_tuser),
    .ctx_o    (ctx),
    .col_o    (ctx_col),
    .row_o    (ctx_row)
  );

  ssclip_clip #(
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM),
    .DimW           (DimW)
  ) u_clip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg),
    .ctx_i  (ctx),
    .col_i  (ctx_col),
    .row_i  (ctx_row),
    .res_o  (res)
  );

  ssclip_addr u_addr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .screen_width_i (cfg.screen_width),
    .res_i          (res),
    .valid_o        (out_valid),
    .dst_o          (dst_index),
    .src_o          (src_index),
    .run_o          (run_length)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, run_length, src_index, dst_index};

endmodule

/* design/ssclip_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ssclip_cfg_regs: configuration registers
// position, clip rectangle and screen stride, written one index at a time
// ----------------------------------------------------------------------------
module ssclip_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ssclip_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ssclip_pkg::WordW-1:0]      cfg_data_i,
  output ssclip_pkg::cfg_t                  cfg_o
);

  ssclip_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (ssclip_pkg::cfg_idx_e'(cfg_index_i))
        ssclip_pkg::CfgSpriteX:     cfg_d.sprite_x     = cfg_data_i;
        ssclip_pkg::CfgSpriteY:     cfg_d.sprite_y     = cfg_data_i;
        ssclip_pkg::CfgClipLeft:    cfg_d.clip_left    = cfg_data_i[ssclip_pkg::ClipW-1:0];
        ssclip_pkg::CfgClipTop:     cfg_d.clip_top     = cfg_data_i[ssclip_pkg::ClipW-1:0];
        ssclip_pkg::CfgClipRight:   cfg_d.clip_right   = cfg_data_i[ssclip_pkg::ClipW-1:0];
        ssclip_pkg::CfgClipBottom:  cfg_d.clip_bottom  = cfg_data_i[ssclip_pkg::ClipW-1:0];
        ssclip_pkg::CfgScreenWidth: cfg_d.screen_width = cfg_data_i[ssclip_pkg::ClipW-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sprite_x     <= '0;
      cfg_q.sprite_y     <= '0;
      cfg_q.clip_left    <= '0;
      cfg_q.clip_top     <= '0;
      cfg_q.clip_right   <= ssclip_pkg::ClipRightRst;
      cfg_q.clip_bottom  <= ssclip_pkg::ClipBottomRst;
      cfg_q.screen_width <= ssclip_pkg::ScreenWidthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/ssclip_span_track.sv */
// ----------------------------------------------------------------------------
// ssclip_span_track: row and span tracker
// decodes headers and span lengths, keeps row, column and source offset
// ----------------------------------------------------------------------------
module ssclip_span_track #(
  parameter int unsigned MAX_SPRITE_DIM = 1024,
  parameter int unsigned DimW           = $clog2(MAX_SPRITE_DIM + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         adv_i,
  input  logic [ssclip_pkg::WordW-1:0] word_i,
  input  logic                         first_i,
  output ssclip_pkg::span_ctx_t        ctx_o,
  output logic [DimW-1:0]              col_o,
  output logic [DimW-1:0]              row_o
);

  localparam int unsigned SumW = ssclip_pkg::WordW + 1;
  localparam logic [DimW-1:0] MaxDim = DimW'(MAX_SPRITE_DIM);
  localparam logic [ssclip_pkg::WordW-2:0] MaxCnt = (ssclip_pkg::WordW-1)'(MAX_SPRITE_DIM);
  localparam logic [SumW-1:0] MaxSum = SumW'(MAX_SPRITE_DIM);

  logic [DimW-1:0]              spans_d, spans_q;
  logic                         draw_d, draw_q;
  logic [DimW-1:0]              row_d, row_q;
  logic [DimW-1:0]              col_d, col_q;
  logic [ssclip_pkg::SrcW-1:0]  src_d, src_q;
  logic [DimW-1:0]              row_base, row_inc, count;
  logic [SumW-1:0]              col_sum;
  logic                         is_header;
  ssclip_pkg::span_ctx_t        ctx_d, ctx_q;
  logic [DimW-1:0]              ctx_col_q, ctx_row_q;

  assign is_header = first_i || (spans_q == '0);
  assign row_base  = first_i ? '0 : row_q;
  assign row_inc   = (row_base < MaxDim) ? row_base + DimW'(1) : row_base;
  assign count     = (word_i[ssclip_pkg::WordW-1:1] > MaxCnt) ? MaxDim :
                     DimW'(word_i[ssclip_pkg::WordW-1:1]);
  assign col_sum   = SumW'(col_q) + SumW'(word_i);

  always_comb begin
    spans_d = spans_q;
    draw_d  = draw_q;
    row_d   = row_q;
    col_d   = col_q;
    src_d   = src_q;
    ctx_d.valid = 1'b0;
    ctx_d.draw  = draw_q;
    ctx_d.len   = word_i;
    ctx_d.src   = src_q;
    if (accept_i) begin
      if (is_header) begin
        spans_d = count;
        draw_d  = word_i[0];
        col_d   = '0;
        src_d   = first_i ? '0 : src_q;
        row_d   = (count == '0) ? row_inc : row_base;
      end else begin
        ctx_d.valid = 1'b1;
        spans_d = spans_q - DimW'(1);
        draw_d  = !draw_q;
        src_d   = src_q + ssclip_pkg::SrcW'(word_i);
        if (spans_q == DimW'(1)) begin
          col_d = '0;
          row_d = row_inc;
        end else begin
          col_d = (col_sum > MaxSum) ? MaxDim : col_sum[DimW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spans_q <= '0;
      draw_q  <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      src_q   <= '0;
    end else begin
      spans_q <= spans_d;
      draw_q  <= draw_d;
      row_q   <= row_d;
      col_q   <= col_d;
      src_q   <= src_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q     <= '0;
      ctx_col_q <= '0;
      ctx_row_q <= '0;
    end else if (adv_i) begin
      ctx_q     <= ctx_d;
      ctx_col_q <= col_q;
      ctx_row_q <= row_q;
    end
  end

  assign ctx_o = ctx_q;
  assign col_o = ctx_col_q;
  assign row_o = ctx_row_q;

endmodule

/* design/ssclip_clip.sv */
// ----------------------------------------------------------------------------
// ssclip_clip: span clipping stage
// places the span on screen and trims it to the clip rectangle and sprite
// ----------------------------------------------------------------------------
module ssclip_clip #(
  parameter int unsigned MAX_SPRITE_DIM = 1024,
  parameter int unsigned DimW           = $clog2(MAX_SPRITE_DIM + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  ssclip_pkg::cfg_t      cfg_i,
  input  ssclip_pkg::span_ctx_t ctx_i,
  input  logic [DimW-1:0]       col_i,
  input  logic [DimW-1:0]       row_i,
  output ssclip_pkg::clip_res_t res_o
);

  localparam int unsigned CW = ssclip_pkg::CoordW;
  localparam logic [DimW-1:0] MaxDim = DimW'(MAX_SPRITE_DIM);
  localparam logic signed [CW-1:0] MaxDimC = CW'(MAX_SPRITE_DIM);

  logic signed [CW-1:0] pos_x, pos_y, row_c, col_c, len_c;
  logic signed [CW-1:0] cl, ct, cr, cb;
  logic signed [CW-1:0] scr_row, span_start, span_end, sprite_end;
  logic signed [CW-1:0] s, e, e_lim, run_c, skip;
  logic                 draw_ok, vis;
  ssclip_pkg::clip_res_t res_d, res_q;

  assign pos_x = {{(CW-ssclip_pkg::WordW){cfg_i.sprite_x[ssclip_pkg::WordW-1]}}, cfg_i.sprite_x};
  assign pos_y = {{(CW-ssclip_pkg::WordW){cfg_i.sprite_y[ssclip_pkg::WordW-1]}}, cfg_i.sprite_y};
  assign row_c = {{(CW-DimW){1'b0}}, row_i};
  assign col_c = {{(CW-DimW){1'b0}}, col_i};
  assign len_c = {{(CW-ssclip_pkg::WordW){1'b0}}, ctx_i.len};
  assign cl    = {{(CW-ssclip_pkg::ClipW){1'b0}}, cfg_i.clip_left};
  assign ct    = {{(CW-ssclip_pkg::ClipW){1'b0}}, cfg_i.clip_top};
  assign cr    = {{(CW-ssclip_pkg::ClipW){1'b0}}, cfg_i.clip_right};
  assign cb    = {{(CW-ssclip_pkg::ClipW){1'b0}}, cfg_i.clip_bottom};

  assign scr_row    = pos_y + row_c;
  assign span_start = pos_x + col_c;
  assign span_end   = span_start + len_c;
  assign sprite_end = pos_x + MaxDimC;

  assign s     = (span_start > cl) ? span_start : cl;
  assign e_lim = (span_end > cr) ? cr : span_end;
  assign e     = (e_lim > sprite_end) ? sprite_end : e_lim;
  assign run_c = e - s;
  assign skip  = s - span_start;

  assign draw_ok = ctx_i.valid && ctx_i.draw && (ctx_i.len != '0) && (row_i < MaxDim) &&
                   (scr_row >= ct) && (scr_row < cb);
  assign vis     = draw_ok && (e > s);

  // on a visible run both the row and the start lie below the 13-bit clip limits
  assign res_d.valid   = vis;
  assign res_d.scr_row = scr_row[ssclip_pkg::ScrW-1:0];
  assign res_d.start   = s[ssclip_pkg::ScrW-1:0];
  assign res_d.src     = ctx_i.src + skip[ssclip_pkg::SrcW-1:0];
  assign res_d.run     = run_c[ssclip_pkg::RunW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* design/ssclip_addr.sv */
// ----------------------------------------------------------------------------
// ssclip_addr: destination address and result register
// row times stride plus start column, held until the item is taken
// ----------------------------------------------------------------------------
module ssclip_addr (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic [ssclip_pkg::ClipW-1:0] screen_width_i,
  input  ssclip_pkg::clip_res_t        res_i,
  output logic                         valid_o,
  output logic [ssclip_pkg::DstW-1:0]  dst_o,
  output logic [ssclip_pkg::SrcW-1:0]  src_o,
  output logic [ssclip_pkg::RunW-1:0]  run_o
);

  localparam int unsigned ProdW = ssclip_pkg::ScrW + ssclip_pkg::ClipW;

  logic [ProdW-1:0]             prod, dst_full;
  logic                         valid_q;
  logic [ssclip_pkg::DstW-1:0]  dst_q;
  logic [ssclip_pkg::SrcW-1:0]  src_q;
  logic [ssclip_pkg::RunW-1:0]  run_q;

  assign prod     = ProdW'(res_i.scr_row) * ProdW'(screen_width_i);
  assign dst_full = prod + ProdW'(res_i.start);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dst_q <= dst_full[ssclip_pkg::DstW-1:0];
      src_q <= res_i.src;
      run_q <= res_i.run;
    end
  end

  assign valid_o = valid_q;
  assign dst_o   = dst_q;
  assign src_o   = src_q;
  assign run_o   = run_q;

endmodule

/* sim/span_sprite_clip_blit_tb.sv */
// ----------------------------------------------------------------------------
// span_sprite_clip_blit_tb: self-checking bench for the span sprite clip blitter
// streams run-length coded sprites through the block under several clip and
// placement windows, predicts every clipped write run and compares each run
// taken from the block, with random gaps and a long hold-off on the run side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module span_sprite_clip_blit_tb;

  localparam int MAX_DIM        = 1024;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [15:0] word;
    logic        first;
  } span_item_t;

  typedef struct packed {
    logic [23:0] dst;
    logic [19:0] src;
    logic [10:0] len;
  } blit_run_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  ssclip_pkg::cfg_idx_e cfg_index_i   = ssclip_pkg::CfgSpriteX;
  logic [15:0]          cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;  // span_word
  logic                 s_axis_tuser  = 1'b0;  // first_word
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [55:0]          m_axis_tdata;  // dst_index, src_index, run_length

  span_item_t span_q[$];
  blit_run_t  run_expect_q[$];
  int         words_queued = 0;
  int         words_taken  = 0;
  int         err_cnt      = 0;
  int         idle_cycles  = 0;
  int         src_wait     = 0;
  int         snk_wait     = 0;
  int         hold_cnt     = 0;
  bit         src_idle_en  = 1'b1;
  bit         snk_idle_en  = 1'b1;
  bit         sink_hold_req = 1'b0;

  // predictor state and shadow of the window registers
  ssclip_pkg::cfg_t win;
  logic [10:0]      spans_left;
  logic             draw_on;
  logic [10:0]      row_pos;
  logic [10:0]      col_pos;
  logic [19:0]      src_pos;

  span_sprite_clip_blit #(
    .MAX_SPRITE_DIM(MAX_DIM)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic close_row();
    col_pos = '0;
    if (row_pos < MAX_DIM) row_pos = row_pos + 1'b1;
  endtask

  // works out the run caused by one span word, if any
  task automatic track_span(input logic [15:0] word, input logic first);
    logic [14:0] count;
    longint      len, scr_row, span_start, span_end, sprite_end, s, e, col, dst, srcv, rlen;
    blit_run_t   hit;
    if (first) begin
      row_pos    = '0;
      col_pos    = '0;
      src_pos    = '0;
      spans_left = '0;
    end
    if (spans_left == 0) begin
      count = word[15:1];
      if (count > 15'(MAX_DIM)) count = 15'(MAX_DIM);
      draw_on    = word[0];
      spans_left = count[10:0];
      col_pos    = '0;
      if (count == 0) close_row();
    end else begin
      len        = longint'(word);
      scr_row    = longint'($signed(win.sprite_y)) + longint'(row_pos);
      span_start = longint'($signed(win.sprite_x)) + longint'(col_pos);
      span_end   = span_start + len;
      sprite_end = longint'($signed(win.sprite_x)) + MAX_DIM;
      if (draw_on && len > 0 && row_pos < MAX_DIM &&
          scr_row >= longint'(win.clip_top) && scr_row < longint'(win.clip_bottom)) begin
        s = (span_start > longint'(win.clip_left)) ? span_start : longint'(win.clip_left);
        e = span_end;
        if (e > longint'(win.clip_right)) e = longint'(win.clip_right);
        if (e > sprite_end) e = sprite_end;
        if (e > s) begin
          dst     = scr_row * longint'(win.screen_width) + s;
          srcv    = longint'(src_pos) + (s - span_start);
          rlen    = e - s;
          hit.dst = dst[23:0];
          hit.src = srcv[19:0];
          hit.len = rlen[10:0];
          run_expect_q.push_back(hit);
        end
      end
      col = longint'(col_pos) + len;
      if (col > MAX_DIM) col = MAX_DIM;
      col_pos    = col[10:0];
      src_pos    = src_pos + 20'(word);
      draw_on    = ~draw_on;
      spans_left = spans_left - 1'b1;
      if (spans_left == 0) close_row();
    end
  endtask

  // span source
  always @(posedge clk_i) begin : span_driver
    span_item_t cur;
    if (s_axis_tvalid && s_axis_tready) begin
      track_span(s_axis_tdata, s_axis_tuser);
      words_taken++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (src_wait > 0) begin
        src_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (span_q.size() != 0) begin
        cur = span_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur.word;
        s_axis_tuser  <= cur.first;
        if (src_idle_en) src_wait = idle_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // run sink and checker
  always @(posedge clk_i) begin : run_monitor
    blit_run_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (run_expect_q.size() == 0) begin
        $error("unexpected run: dst_index %0d src_index %0d run_length %0d",
               m_axis_tdata[23:0], m_axis_tdata[43:24], m_axis_tdata[54:44]);
        err_cnt++;
      end else begin
        want = run_expect_q.pop_front();
        if (m_axis_tdata[23:0] !== want.dst) begin
          $error("dst_index: expected %0d, got %0d", want.dst, m_axis_tdata[23:0]);
          err_cnt++;
        end
        if (m_axis_tdata[43:24] !== want.src) begin
          $error("src_index: expected %0d, got %0d", want.src, m_axis_tdata[43:24]);
          err_cnt++;
        end
        if (m_axis_tdata[54:44] !== want.len) begin
          $error("run_length: expected %0d, got %0d", want.len, m_axis_tdata[54:44]);
          err_cnt++;
        end
      end
    end
    if (sink_hold_req) begin
      sink_hold_req = 1'b0;
      hold_cnt      = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (snk_wait > 0) begin
      snk_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (snk_idle_en) snk_wait = idle_len();
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("span_sprite_clip_blit: mismatch");
      $finish;
    end
  end

  task automatic push_word(input logic [15:0] w, input logic f);
    span_q.push_back('{word: w, first: f});
    words_queued++;
  endtask

  task automatic write_reg(input ssclip_pkg::cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    unique case (idx)
      ssclip_pkg::CfgSpriteX:     win.sprite_x     = val;
      ssclip_pkg::CfgSpriteY:     win.sprite_y     = val;
      ssclip_pkg::CfgClipLeft:    win.clip_left    = val[12:0];
      ssclip_pkg::CfgClipTop:     win.clip_top     = val[12:0];
      ssclip_pkg::CfgClipRight:   win.clip_right   = val[12:0];
      ssclip_pkg::CfgClipBottom:  win.clip_bottom  = val[12:0];
      ssclip_pkg::CfgScreenWidth: win.screen_width = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_window(input int sx, input int sy, input int cl, input int ct,
                            input int cr, input int cb, input int sw);
    write_reg(ssclip_pkg::CfgSpriteX, 16'(sx));
    write_reg(ssclip_pkg::CfgSpriteY, 16'(sy));
    write_reg(ssclip_pkg::CfgClipLeft, 16'(cl));
    write_reg(ssclip_pkg::CfgClipTop, 16'(ct));
    write_reg(ssclip_pkg::CfgClipRight, 16'(cr));
    write_reg(ssclip_pkg::CfgClipBottom, 16'(cb));
    write_reg(ssclip_pkg::CfgScreenWidth, 16'(sw));
  endtask

  // clip window at a random spot with the sprite placed near it
  task automatic random_window();
    int cl, ct;
    cl = $urandom_range(0, 600);
    ct = $urandom_range(0, 600);
    set_window(cl + int'($urandom_range(0, 300)) - 150, ct + int'($urandom_range(0, 12)) - 6,
               cl, ct, cl + int'($urandom_range(1, 700)), ct + int'($urandom_range(1, 300)),
               int'($urandom_range(1, 4096)));
  endtask

  task automatic drain();
    while (words_taken != words_queued) @(posedge clk_i);
    while (run_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_len(input bit heavy);
    int r;
    r = $urandom_range(0, 99);
    if (heavy) return 16'(16'hF000 | $urandom_range(0, 16'h0FFF));
    if (r < 12) return '0;
    if (r < 70) return 16'($urandom_range(1, 40));
    if (r < 90) return 16'($urandom_range(41, 1100));
    return 16'($urandom());
  endfunction

  task automatic queue_sprite(input int rows);
    int r, n;
    bit heavy;
    for (int row = 0; row < rows; row++) begin
      r     = $urandom_range(0, 99);
      heavy = (r < 3);
      if (heavy) n = 18;
      else if (r < 13) n = 0;
      else if (r < 88) n = $urandom_range(1, 8);
      else n = $urandom_range(9, 24);
      // oversized span count, left unfinished for the next sprite
      if (r >= 97) begin
        push_word({15'($urandom_range(MAX_DIM + 1, 32767)), 1'($urandom_range(0, 1))},
                  row == 0);
        repeat ($urandom_range(1, 6)) push_word(pick_len(1'b0), 1'b0);
        return;
      end
      push_word({15'(n), 1'($urandom_range(0, 1))}, row == 0);
      for (int k = 0; k < n; k++) begin
        if (k > 0 && $urandom_range(0, 99) < 2) return;
        push_word(pick_len(heavy), 1'b0);
      end
    end
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 6)) push_word(16'($urandom()), $urandom_range(0, 9) == 0);
  endtask

  initial begin
    int start, budget;
    win.sprite_x     = '0;
    win.sprite_y     = '0;
    win.clip_left    = '0;
    win.clip_top     = '0;
    win.clip_right   = ssclip_pkg::ClipRightRst;
    win.clip_bottom  = ssclip_pkg::ClipBottomRst;
    win.screen_width = ssclip_pkg::ScreenWidthRst;
    spans_left = '0;
    draw_on    = 1'b0;
    row_pos    = '0;
    col_pos    = '0;
    src_pos    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed sprite under the reset window
    push_word(16'h0005, 1'b1);
    push_word(16'd10, 1'b0);
    push_word(16'd5, 1'b0);
    push_word(16'h0007, 1'b0);
    push_word(16'd0, 1'b0);
    push_word(16'd4, 1'b0);
    push_word(16'd6, 1'b0);
    push_word(16'h0000, 1'b0);
    push_word(16'h0001, 1'b0);
    push_word(16'h0005, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'd5, 1'b0);
    push_word(16'h0007, 1'b0);
    push_word(16'd3, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'd9, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'd3, 1'b0);
    push_word(16'd2, 1'b0);
    push_word(16'h0003, 1'b1);
    push_word(16'd7, 1'b0);
    push_word(16'h0004, 1'b0);
    push_word(16'd1, 1'b0);
    push_word(16'd8, 1'b0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      budget      = 100;
      src_idle_en = 1'b1;
      snk_idle_en = 1'b1;
      case (ph)
        1: begin
          random_window();
          src_idle_en = 1'b0;
          snk_idle_en = 1'b0;
        end
        2: begin
          random_window();
          src_idle_en   = 1'b0;
          snk_idle_en   = 1'b0;
          sink_hold_req = 1'b1;
        end
        3: begin
          set_window(-32768, -32768, 0, 0, 4096, 4096, 4096);
          budget = 40;
        end
        4: begin
          set_window(32767, 32767, 0, 0, 4096, 4096, 1);
          budget = 40;
        end
        5: begin
          // empty clip in both directions
          set_window(10, 0, 300, 150, 300, 100, 320);
          budget = 40;
        end
        6: set_window(3500, 3996, 3000, 4000, 4096, 4096, 4096);
        7: set_window(-20, 0, 5, 2, 40, 6, 1);
        8: begin
          random_window();
          src_idle_en = 1'b0;
        end
        9: begin
          random_window();
          snk_idle_en = 1'b0;
        end
        default: random_window();
      endcase
      start = words_queued;
      while (words_queued - start < budget) begin
        if ($urandom_range(0, 99) < 85) queue_sprite($urandom_range(1, 8));
        else queue_noise();
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("span_sprite_clip_blit: match");
    end else begin
      $display("span_sprite_clip_blit: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ssclip_pkg.sv
design/ssclip_cfg_regs.sv
design/ssclip_span_track.sv
design/ssclip_clip.sv
design/ssclip_addr.sv
design/span_sprite_clip_blit.sv
sim/span_sprite_clip_blit_tb.sv
